FILE: hdl/assert_macros.svh
// assertion macros shared by the sprite frame sequencer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   `ASSERT_PROP(name, clk, rst, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   `ASSERT_PROP(name, clk, rst, (ante) |=> (cons), msg)

`endif

FILE: hdl/sfs_pkg.sv
// types, constants and command codes of the sprite frame sequencer
package sfs_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int TIME_WIDTH = 16;
   localparam int POS_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FRAMES_W   = $clog2(MAX_FRAMES + 1);
   localparam int ACC_W      = TIME_WIDTH + 1;
   localparam int DSR_W      = (TIME_WIDTH > FRAMES_W) ? TIME_WIDTH : FRAMES_W;
   localparam int DVD_W      = ACC_W + 1;
   localparam int CNT_W      = $clog2(DVD_W + 1);
   localparam int FNUM_W     = 16;

   typedef enum logic [3:0] {
      REQ_TICK   = 4'd0,
      REQ_PLAY   = 4'd1,
      REQ_STOP   = 4'd2,
      REQ_PAUSE  = 4'd3,
      REQ_RESUME = 4'd4,
      REQ_RESET  = 4'd5,
      REQ_ATTACH = 4'd6,
      REQ_DETACH = 4'd7,
      REQ_LOAD   = 4'd8
   } req_code_type;

   typedef struct packed {
      logic [15:0] slot_value;
      logic [5:0]  slot;
      logic        anim_loops;
      logic [15:0] anim_period;
      logic [6:0]  anim_frames;
      logic        replay_same;
      logic        anim_found;
      logic [7:0]  anim_id;
      logic [15:0] delta_ticks;
   } req_data_type;

   typedef struct packed {
      logic [5:0]  fill;
      logic        is_finished;
      logic        is_paused;
      logic        is_playing;
      logic        frame_valid;
      logic [15:0] frame_number;
      logic [5:0]  position;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic fix;
      logic mod_done;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic tick_go;
      logic loop;
      logic div_last;
   } stat_type;

endpackage

FILE: hdl/sprite_frame_sequencer.sv
// top level of the sprite frame sequencer
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    req_tdata (72 bits), req_tuser (command)
//  rsp      out  rsp_tvalid/tready    rsp_tdata (32 bits)
//
// an item that is not a tick on a running, unpaused animation passes from exec
// to read and out; such a tick goes through the divider before read:
// one bit-serial divider pass of DVD_W (18) steps splits the time, a second
// pass wraps the position when looping
// reset is synchronous and active high; the frame table is not cleared
// the next item is accepted while a result waits in the output register;
// a stalled output holds the controller only when a newer result is ready
module sprite_frame_sequencer import sfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // delta_ticks, anim_id, anim_found, replay_same, anim_frames,
   // anim_period, anim_loops, slot, slot_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [3:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // position, frame_number, frame_valid, is_playing, is_paused, is_finished, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type      cmd;
   stat_type     stat;
   req_data_type req_data;
   rsp_data_type rsp_data;

   assign req_data  = req_data_type'(req_tdata);
   assign rsp_tdata = RSP_DATA_W'(rsp_data);

   sfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sfs_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_type (req_tuser),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/sfs_ram.sv
// generic single-port-write ram with registered read
module sfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sfs_ctrl.sv
// controller state machine of the sprite frame sequencer
`include "assert_macros.svh"

module sfs_ctrl import sfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIX,
      ST_MOD,
      ST_MODFIX,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;
   logic      accept;
   logic      out_free;

   assign accept   = req_tvalid && req_tready_ff;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.div_step = (state_ff == ST_DIV) || (state_ff == ST_MOD);
      cmd.fix      = (state_ff == ST_FIX);
      cmd.mod_done = (state_ff == ST_MODFIX);
      cmd.load_out = (state_ff == ST_OUT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         req_tready_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_tready_ff <= 1'b0;
                  state_ff      <= ST_EXEC;
               end else begin
                  req_tready_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff <= stat.tick_go ? ST_DIV : ST_READ;
            end
            ST_DIV: begin
               if (stat.div_last) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               state_ff <= stat.loop ? ST_MOD : ST_READ;
            end
            ST_MOD: begin
               if (stat.div_last) begin
                  state_ff <= ST_MODFIX;
               end
            end
            ST_MODFIX: begin
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  req_tready_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   `ASSERT_IMPLY(a_ready_only_idle, clock, reset, req_tready_ff, state_ff == ST_IDLE,
      "input ready outside idle")
   `ASSERT_NEXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC,
      "accepted item not executed")
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_tvalid_ff,
      "loaded result not presented")

endmodule

FILE: hdl/sfs_dp.sv
// datapath of the sprite frame sequencer: playback state, divider, frame table
`include "assert_macros.svh"

module sfs_dp import sfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  logic [3:0]   req_type,
   input  req_data_type req_data,
   output rsp_data_type rsp_data
);

   logic [3:0]            req_type_ff;
   req_data_type          req_ff;
   logic                  sprite_ff;
   logic                  anim_ff;
   logic [7:0]            cur_ff;
   logic [FRAMES_W-1:0]   total_ff;
   logic [TIME_WIDTH-1:0] period_ff;
   logic                  loop_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic                  run_ff;
   logic                  pause_ff;
   logic                  done_ff;

   logic [DVD_W-1:0]      dvd_ff;
   logic [DSR_W-1:0]      dsr_ff;
   logic [DSR_W-1:0]      rem_ff;
   logic [DVD_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   rsp_data_type          rsp_ff;

   logic [TIME_WIDTH-1:0] delta_t;
   logic [FRAMES_W-1:0]   frames_sat;
   logic                  play_same;
   logic [DSR_W:0]        shift_v;
   logic                  fits;
   logic [FRAMES_W-1:0]   left;
   logic                  finish;
   logic                  slot_ok;
   logic                  wr_en;
   logic                  valid;
   logic [FNUM_W-1:0]     rd_data;

   assign delta_t    = TIME_WIDTH'(req_ff.delta_ticks);
   assign frames_sat = (32'(req_ff.anim_frames) > MAX_FRAMES) ? FRAMES_W'(MAX_FRAMES)
                                                                : FRAMES_W'(req_ff.anim_frames);
   assign play_same  = anim_ff && (cur_ff == req_ff.anim_id) && !req_ff.replay_same;
   assign shift_v    = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits       = shift_v >= {1'b0, dsr_ff};
   assign left       = total_ff - FRAMES_W'(pos_ff);
   assign finish     = quo_ff >= DVD_W'(left);
   assign slot_ok    = 32'(req_ff.slot) < MAX_FRAMES;
   assign wr_en      = cmd.exec && (req_type_ff == REQ_LOAD) && slot_ok;
   assign valid      = sprite_ff && anim_ff && (total_ff != '0) &&
                       (FRAMES_W'(pos_ff) < total_ff);

   assign stat.tick_go  = (req_type_ff == REQ_TICK) && sprite_ff && anim_ff && run_ff &&
                          !pause_ff && !done_ff && (delta_t != '0) && (total_ff != '0) &&
                          (period_ff != '0);
   assign stat.loop     = loop_ff;
   assign stat.div_last = (cnt_ff == CNT_W'(1));

   sfs_ram #(
      .WIDTH (FNUM_W),
      .DEPTH (MAX_FRAMES)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (POS_W'(req_ff.slot)),
      .wr_data (req_ff.slot_value),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_ff <= 1'b0;
         anim_ff   <= 1'b0;
         cur_ff    <= '0;
         total_ff  <= '0;
         period_ff <= '0;
         loop_ff   <= 1'b0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         run_ff    <= 1'b0;
         pause_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (cmd.exec) begin
            case (req_code_type'(req_type_ff))
               REQ_TICK: begin
               end
               REQ_PLAY: begin
                  if (sprite_ff && req_ff.anim_found) begin
                     if (play_same) begin
                        if (!done_ff) begin
                           run_ff   <= 1'b1;
                           pause_ff <= 1'b0;
                        end
                     end else begin
                        anim_ff   <= 1'b1;
                        cur_ff    <= req_ff.anim_id;
                        total_ff  <= frames_sat;
                        period_ff <= TIME_WIDTH'(req_ff.anim_period);
                        loop_ff   <= req_ff.anim_loops;
                        pos_ff    <= '0;
                        acc_ff    <= '0;
                        run_ff    <= 1'b1;
                        pause_ff  <= 1'b0;
                        done_ff   <= 1'b0;
                     end
                  end
               end
               REQ_STOP: begin
                  pos_ff   <= '0;
                  acc_ff   <= '0;
                  run_ff   <= 1'b0;
                  pause_ff <= 1'b0;
                  done_ff  <= 1'b0;
               end
               REQ_PAUSE: begin
                  if (run_ff) begin
                     pause_ff <= 1'b1;
                  end
               end
               REQ_RESUME: begin
                  if (run_ff) begin
                     pause_ff <= 1'b0;
                  end
               end
               REQ_RESET: begin
                  pos_ff   <= '0;
                  acc_ff   <= '0;
                  pause_ff <= 1'b0;
                  done_ff  <= 1'b0;
                  run_ff   <= anim_ff;
               end
               REQ_ATTACH, REQ_DETACH: begin
                  sprite_ff <= (req_type_ff == REQ_ATTACH);
                  anim_ff   <= 1'b0;
                  pos_ff    <= '0;
                  acc_ff    <= '0;
                  run_ff    <= 1'b0;
                  pause_ff  <= 1'b0;
                  done_ff   <= 1'b0;
               end
               REQ_LOAD: begin
               end
               default: begin
               end
            endcase
         end
         if (cmd.fix) begin
            if (loop_ff) begin
               acc_ff <= ACC_W'(rem_ff);
            end else if (finish) begin
               pos_ff  <= POS_W'(total_ff - FRAMES_W'(1));
               done_ff <= 1'b1;
               run_ff  <= 1'b0;
               acc_ff  <= '0;
            end else begin
               pos_ff <= pos_ff + POS_W'(quo_ff);
               acc_ff <= ACC_W'(rem_ff);
            end
         end
         if (cmd.mod_done) begin
            pos_ff <= POS_W'(rem_ff);
         end
      end
   end

   // item capture, bit-serial restoring divider, result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         req_ff      <= req_data;
      end
      if (cmd.exec) begin
         dvd_ff <= DVD_W'(acc_ff) + DVD_W'(delta_t);
         dsr_ff <= DSR_W'(period_ff);
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= CNT_W'(DVD_W);
      end
      if (cmd.fix) begin
         dvd_ff <= DVD_W'(pos_ff) + quo_ff;
         dsr_ff <= DSR_W'(total_ff);
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= CNT_W'(DVD_W);
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff <= fits ? DSR_W'(shift_v - {1'b0, dsr_ff}) : DSR_W'(shift_v);
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.load_out) begin
         rsp_ff.fill         <= '0;
         rsp_ff.is_finished  <= done_ff;
         rsp_ff.is_paused    <= pause_ff;
         rsp_ff.is_playing   <= run_ff;
         rsp_ff.frame_valid  <= valid;
         rsp_ff.frame_number <= valid ? rd_data : '0;
         rsp_ff.position     <= 6'(pos_ff);
      end
   end

   assign rsp_data = rsp_ff;

   `ASSERT_IMPLY(a_pause_needs_run, clock, reset, pause_ff, run_ff,
      "paused without playing")
   `ASSERT_PROP(a_run_not_done, clock, reset, !(run_ff && done_ff),
      "playing and finished together")
   `ASSERT_IMPLY(a_pos_in_range, clock, reset, anim_ff && (total_ff != '0),
      FRAMES_W'(pos_ff) < total_ff, "position beyond frame count")

endmodule

FILE: test/tb_sprite_frame_sequencer.sv
// testbench for the sprite frame sequencer: directed and random commands checked against a predictor
module tb_sprite_frame_sequencer import sfs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

   class anim_scoreboard;
      bit sprite_on;
      bit anim_on;
      bit looping;
      bit playing;
      bit paused;
      bit finished;
      int anim_sel;
      int frame_count;
      int frame_period;
      int pos;
      int acc;
      bit [15:0] frame_table [MAX_FRAMES];
      rsp_data_type expected_status [$];
      int faults;

      function int pending();
         return expected_status.size();
      endfunction

      function void drop_playback();
         pos = 0;
         acc = 0;
         playing = 0;
         paused = 0;
         finished = 0;
      endfunction

      function void note_command(logic [3:0] code, req_data_type d);
         int frames;
         int last;
         bit valid;
         rsp_data_type e;
         case (code)
            REQ_TICK: begin
               if (sprite_on && anim_on && playing && !paused && !finished &&
                   d.delta_ticks != 0 && frame_count != 0 && frame_period != 0) begin
                  last = frame_count - 1;
                  acc += d.delta_ticks;
                  while (acc >= frame_period) begin
                     acc -= frame_period;
                     if (pos < last) begin
                        pos++;
                     end else if (looping) begin
                        pos = 0;
                     end else begin
                        pos = last;
                        finished = 1;
                        playing = 0;
                        break;
                     end
                  end
               end
            end
            REQ_PLAY: begin
               if (sprite_on && d.anim_found) begin
                  if (anim_on && anim_sel == d.anim_id && !d.replay_same) begin
                     if (!finished) begin
                        playing = 1;
                        paused = 0;
                     end
                  end else begin
                     frames = d.anim_frames;
                     if (frames > MAX_FRAMES) frames = MAX_FRAMES;
                     anim_on = 1;
                     anim_sel = d.anim_id;
                     frame_count = frames;
                     frame_period = d.anim_period;
                     looping = d.anim_loops;
                     drop_playback();
                     playing = 1;
                  end
               end
            end
            REQ_STOP: drop_playback();
            REQ_PAUSE: if (playing) paused = 1;
            REQ_RESUME: if (playing) paused = 0;
            REQ_RESET: begin
               pos = 0;
               acc = 0;
               paused = 0;
               finished = 0;
               playing = anim_on;
            end
            REQ_ATTACH, REQ_DETACH: begin
               sprite_on = (code == REQ_ATTACH);
               anim_on = 0;
               drop_playback();
            end
            REQ_LOAD: frame_table[d.slot] = d.slot_value;
            default: ;
         endcase
         valid = sprite_on && anim_on && frame_count > 0 && pos < frame_count;
         e = '0;
         e.position = 6'(pos);
         e.frame_number = valid ? frame_table[pos] : 16'd0;
         e.frame_valid = valid;
         e.is_playing = playing;
         e.is_paused = paused;
         e.is_finished = finished;
         expected_status.push_back(e);
      endfunction

      function void check_status(rsp_data_type got);
         rsp_data_type e;
         if (expected_status.size() == 0) begin
            faults++;
            if (faults <= 10) $display("tb: status with no item pending: %h", got);
            return;
         end
         e = expected_status.pop_front();
         if (got.position !== e.position || got.frame_number !== e.frame_number ||
             got.frame_valid !== e.frame_valid || got.is_playing !== e.is_playing ||
             got.is_paused !== e.is_paused || got.is_finished !== e.is_finished ||
             got.fill !== e.fill) begin
            faults++;
            if (faults <= 10)
               $display("tb: mismatch expected %h got %h", e, got);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [3:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   anim_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int rsp_hold_cycles = 0;

   sprite_frame_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
   end

   function automatic req_data_type noise();
      return {$urandom(), $urandom(), 8'($urandom())};
   endfunction

   task automatic send_item(input logic [3:0] code, input req_data_type d);
      @(negedge clock);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(code, d);
   endtask

   task automatic send_cmd(input logic [3:0] code);
      send_item(code, noise());
   endtask

   task automatic send_tick(input int delta);
      req_data_type d;
      d = noise();
      d.delta_ticks = 16'(delta);
      send_item(REQ_TICK, d);
   endtask

   task automatic send_play(input int id, input int found, input int restart,
                            input int frames, input int period, input int loops);
      req_data_type d;
      d = noise();
      d.anim_id = 8'(id);
      d.anim_found = 1'(found);
      d.replay_same = 1'(restart);
      d.anim_frames = 7'(frames);
      d.anim_period = 16'(period);
      d.anim_loops = 1'(loops);
      send_item(REQ_PLAY, d);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void pick_item(output logic [3:0] code, output req_data_type d);
      int roll;
      d = noise();
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         code = REQ_TICK;
         roll = $urandom_range(0, 9);
         if (roll == 0) d.delta_ticks = '0;
         else if (roll < 7) d.delta_ticks = 16'($urandom_range(1, 400));
      end else if (roll < 57) begin
         code = REQ_PLAY;
         d.anim_found = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 9) < 6) d.anim_id = 8'($urandom_range(0, 3));
         roll = $urandom_range(0, 9);
         if (roll < 6) d.anim_frames = 7'($urandom_range(1, 16));
         else if (roll == 6) d.anim_frames = 7'($urandom_range(17, 64));
         else if (roll == 7) d.anim_frames = '0;
         else if (roll == 8) d.anim_frames = 7'($urandom_range(65, 127));
         roll = $urandom_range(0, 9);
         if (roll < 7) d.anim_period = 16'($urandom_range(1, 300));
         else if (roll == 7) d.anim_period = '0;
      end else if (roll < 62) begin
         code = REQ_PAUSE;
      end else if (roll < 67) begin
         code = REQ_RESUME;
      end else if (roll < 70) begin
         code = REQ_STOP;
      end else if (roll < 74) begin
         code = REQ_RESET;
      end else if (roll < 79) begin
         code = REQ_ATTACH;
      end else if (roll < 81) begin
         code = REQ_DETACH;
      end else if (roll < 95) begin
         code = REQ_LOAD;
      end else begin
         code = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
      end
   endfunction

   initial begin
      logic [3:0] code;
      req_data_type d;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole frame table so no unwritten entry is ever read
      for (int s = 0; s < MAX_FRAMES; s++) begin
         d = noise();
         d.slot = 6'(s);
         if (s == 0) d.slot_value = 16'hffff;
         if (s == MAX_FRAMES - 1) d.slot_value = '0;
         send_item(REQ_LOAD, d);
      end

      send_cmd(REQ_UNKNOWN_LO);
      send_tick(50);
      send_play(5, 1, 0, 3, 10, 0);
      send_cmd(REQ_PAUSE);
      send_cmd(REQ_ATTACH);
      send_play(5, 0, 0, 3, 10, 0);
      send_play(5, 1, 0, 3, 10, 0);
      send_tick(0);
      send_tick(25);
      send_tick(65535);
      send_play(5, 1, 0, 3, 10, 0);
      send_cmd(REQ_RESUME);
      send_play(5, 1, 1, 3, 10, 0);
      send_cmd(REQ_PAUSE);
      send_tick(25);
      send_play(5, 1, 0, 9, 1, 1);
      send_tick(15);
      send_cmd(REQ_RESET);
      send_play(255, 1, 0, 127, 1, 1);
      send_tick(65535);
      send_play(0, 1, 0, 0, 5, 1);
      send_tick(100);
      send_play(7, 1, 0, 64, 0, 0);
      send_tick(65535);
      send_cmd(REQ_STOP);
      send_cmd(REQ_DETACH);
      send_tick(10);
      send_cmd(REQ_UNKNOWN_HI);
      send_cmd(REQ_ATTACH);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            1: begin tx_idle_pct = 57; rx_stall_pct = 0; end
            2: begin tx_idle_pct = 0; rx_stall_pct = 57; end
            default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
         endcase
         for (int i = 0; i < 150; i++) begin
            pick_item(code, d);
            send_item(code, d);
            if (phase == 0 && i == 40) rsp_hold_cycles = 300;
         end
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sprite_frame_sequencer.f
+incdir+hdl
hdl/sfs_pkg.sv
hdl/sfs_ram.sv
hdl/sfs_ctrl.sv
hdl/sfs_dp.sv
hdl/sprite_frame_sequencer.sv
test/tb_sprite_frame_sequencer.sv
